/* rtl/core/at_response_recognizer_top_macros.svh */
// Assertion macros for the AT response recognizer.
// Included by the top level; it has no other dependencies.
`ifndef AT_RESPONSE_RECOGNIZER_TOP_MACROS_SVH
`define AT_RESPONSE_RECOGNIZER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ATR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ATR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ATR_ASSERT(lbl, prop, msg)
`define ATR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/core/atr_pkg.sv */
// Types and constants of the AT response recognizer.
// Used by atr_matcher and at_response_recognizer_top; no dependencies.
package atr_pkg;

  localparam int unsigned FlagW = 10;

  localparam int unsigned FLAG_OK     = 0;
  localparam int unsigned FLAG_PROMPT = 1;
  localparam int unsigned FLAG_SENT   = 2;
  localparam int unsigned FLAG_SIGNAL = 3;
  localparam int unsigned FLAG_REG    = 4;
  localparam int unsigned FLAG_BEARER = 6;
  localparam int unsigned FLAG_DLOAD  = 7;
  localparam int unsigned FLAG_HTTP   = 8;
  localparam int unsigned FLAG_ERROR  = 9;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_W     = 8'h57;

  typedef enum logic [6:0] {
    P_IDLE        = 7'd0,
    P_O_WAIT      = 7'd1,
    P_GT_WAIT     = 7'd10,
    P_PROMPT      = 7'd11,
    P_PLUS        = 7'd12,
    P_C           = 7'd13,
    P_CM          = 7'd14,
    P_CMG         = 7'd15,
    P_CS          = 7'd20,
    P_CSQ         = 7'd21,
    P_CSQ_COL     = 7'd22,
    P_CSQ_SP      = 7'd23,
    P_CSQ_D1      = 7'd24,
    P_CSQ_D2      = 7'd25,
    P_CSQ_COM     = 7'd26,
    P_CR          = 7'd30,
    P_CRE         = 7'd31,
    P_CREG        = 7'd32,
    P_CREG_COL    = 7'd33,
    P_CREG_SP     = 7'd34,
    P_CREG_0      = 7'd35,
    P_CREG_COM    = 7'd36,
    P_S           = 7'd40,
    P_SA          = 7'd41,
    P_SAP         = 7'd42,
    P_SAPB        = 7'd43,
    P_SAPBR       = 7'd44,
    P_SAPBR_COL   = 7'd45,
    P_SAPBR_SP    = 7'd46,
    P_SAPBR_1     = 7'd47,
    P_SAPBR_COM   = 7'd48,
    P_D           = 7'd50,
    P_DO          = 7'd51,
    P_DOW         = 7'd52,
    P_DOWN        = 7'd53,
    P_DOWNL       = 7'd54,
    P_DOWNLO      = 7'd55,
    P_DOWNLOA     = 7'd56,
    P_H           = 7'd60,
    P_HT          = 7'd61,
    P_HTT         = 7'd62,
    P_HTTP        = 7'd63,
    P_HTTPA       = 7'd64,
    P_HTTPAC      = 7'd65,
    P_HTTPACT     = 7'd66,
    P_HTTPACTI    = 7'd67,
    P_HTTPACTIO   = 7'd68,
    P_HTTPACTION  = 7'd69,
    P_HA_COL      = 7'd70,
    P_HA_SP       = 7'd71,
    P_HA_1        = 7'd72,
    P_HA_COM      = 7'd73,
    P_HA_D1       = 7'd74,
    P_HA_DN       = 7'd75,
    P_E           = 7'd80,
    P_ER          = 7'd81,
    P_ERRO        = 7'd82
  } pos_e;

  typedef struct packed {
    pos_e             pos;
    logic [FlagW-1:0] set;
  } step_t;

endpackage

/* rtl/core/at_response_recognizer_top.sv */
// Top level of the AT response recognizer: input register, matcher, result register.
// Depends on atr_pkg, atr_matcher and at_response_recognizer_top_macros.svh.
// A beat is held in the input register, then moves through the matcher into the result register.
// Throughput: one beat per cycle unless the output stalls; position and flags update per beat.
// While a result waits, the input register takes a new beat only when it is empty.
// Reset (rst_ni low, asynchronous) empties both registers, idles the matcher, clears flags.
`include "at_response_recognizer_top_macros.svh"

module at_response_recognizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] rx_byte, [17:8] clear_mask, rest zero
  input  logic        s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [9:0] response_flags, [10] mid_match, rest zero
);

  localparam int unsigned FlagW = atr_pkg::FlagW;

  logic                 in_valid_q;
  logic                 in_op_q;
  logic [7:0]           in_byte_q;
  logic [FlagW-1:0]     in_mask_q;
  logic                 out_valid_q;
  logic [FlagW:0]       out_data_q;
  atr_pkg::pos_e        pos_q, pos_d;
  logic [FlagW-1:0]     flags_q, flags_d;
  atr_pkg::step_t       step;
  logic                 out_ready;
  logic                 in_ready;
  logic                 adv;
  logic                 byte_adv;

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign in_ready  = !in_valid_q || out_ready;
  assign adv       = in_valid_q && out_ready;
  assign byte_adv  = adv && (in_op_q == atr_pkg::OP_BYTE);

  atr_matcher u_matcher (
    .pos_i  (pos_q),
    .byte_i (in_byte_q),
    .step_o (step)
  );

  always_comb begin
    if (in_op_q == atr_pkg::OP_CLEAR) begin
      pos_d   = pos_q;
      flags_d = flags_q & ~in_mask_q;
    end else begin
      pos_d   = step.pos;
      flags_d = flags_q | step.set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= atr_pkg::P_IDLE;
      flags_q     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_d;
        flags_q     <= flags_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_op_q   <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i[7:0];
      in_mask_q <= s_axis_tdata_i[17:8];
    end
    if (adv) begin
      out_data_q <= {(pos_d != atr_pkg::P_IDLE), flags_d};
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - FlagW - 1){1'b0}}, out_data_q};

  `ATR_ASSERT(a_bit5_never_set, m_axis_tvalid_o |-> !m_axis_tdata_o[5], "flag bit 5 was set")
  `ATR_ASSERT(a_byte_keeps_flags, byte_adv |=> (($past(flags_q) & ~flags_q) == '0), "flag lost")
  `ATR_ASSERT(a_ready_when_empty, !out_valid_q |-> s_axis_tready_o, "input stalled with empty output")
  `ATR_ASSERT_RST(a_reset_idle, !rst_ni |=> (!m_axis_tvalid_o || rst_ni), "output valid during reset")

endmodule

/* rtl/core/atr_matcher.sv */
// Keyword matcher: next recognizer position and flags to set for one byte.
// Pure combinational logic; depends on atr_pkg.
module atr_matcher (
  input  atr_pkg::pos_e  pos_i,
  input  logic [7:0]     byte_i,
  output atr_pkg::step_t step_o
);

  atr_pkg::pos_e                 pos_nxt;
  logic [atr_pkg::FlagW-1:0]     set_nxt;
  logic                          is_digit;

  function automatic atr_pkg::pos_e expect_ch(logic [7:0] c, logic [7:0] want,
                                              atr_pkg::pos_e nxt);
    return (c == want) ? nxt : atr_pkg::P_IDLE;
  endfunction

  assign is_digit = (byte_i >= atr_pkg::CH_0) && (byte_i <= atr_pkg::CH_9);

  always_comb begin
    pos_nxt = atr_pkg::P_IDLE;
    unique case (pos_i)
      atr_pkg::P_IDLE: begin
        priority if (byte_i == atr_pkg::CH_O)    pos_nxt = atr_pkg::P_O_WAIT;
        else if (byte_i == atr_pkg::CH_PLUS)     pos_nxt = atr_pkg::P_PLUS;
        else if (byte_i == atr_pkg::CH_GT)       pos_nxt = atr_pkg::P_GT_WAIT;
        else if (byte_i == atr_pkg::CH_D)        pos_nxt = atr_pkg::P_D;
        else if (byte_i == atr_pkg::CH_E)        pos_nxt = atr_pkg::P_E;
        else                                     pos_nxt = atr_pkg::P_IDLE;
      end
      atr_pkg::P_O_WAIT:
        pos_nxt = (byte_i == atr_pkg::CH_K) ? atr_pkg::P_IDLE : atr_pkg::P_O_WAIT;
      atr_pkg::P_GT_WAIT:
        pos_nxt = (byte_i == atr_pkg::CH_SP) ? atr_pkg::P_PROMPT : atr_pkg::P_GT_WAIT;
      atr_pkg::P_PROMPT: pos_nxt = expect_ch(byte_i, atr_pkg::CH_PLUS, atr_pkg::P_PLUS);
      atr_pkg::P_PLUS: begin
        priority if (byte_i == atr_pkg::CH_C) pos_nxt = atr_pkg::P_C;
        else if (byte_i == atr_pkg::CH_S)     pos_nxt = atr_pkg::P_S;
        else if (byte_i == atr_pkg::CH_H)     pos_nxt = atr_pkg::P_H;
        else                                  pos_nxt = atr_pkg::P_IDLE;
      end
      atr_pkg::P_C: begin
        priority if (byte_i == atr_pkg::CH_M) pos_nxt = atr_pkg::P_CM;
        else if (byte_i == atr_pkg::CH_S)     pos_nxt = atr_pkg::P_CS;
        else if (byte_i == atr_pkg::CH_R)     pos_nxt = atr_pkg::P_CR;
        else                                  pos_nxt = atr_pkg::P_IDLE;
      end
      atr_pkg::P_CM:        pos_nxt = expect_ch(byte_i, atr_pkg::CH_G, atr_pkg::P_CMG);
      atr_pkg::P_CS:        pos_nxt = expect_ch(byte_i, atr_pkg::CH_Q, atr_pkg::P_CSQ);
      atr_pkg::P_CSQ:       pos_nxt = expect_ch(byte_i, atr_pkg::CH_COLON, atr_pkg::P_CSQ_COL);
      atr_pkg::P_CSQ_COL:   pos_nxt = expect_ch(byte_i, atr_pkg::CH_SP, atr_pkg::P_CSQ_SP);
      atr_pkg::P_CSQ_SP:
        pos_nxt = (byte_i >= atr_pkg::CH_1 && byte_i <= atr_pkg::CH_3) ?
                  atr_pkg::P_CSQ_D1 : atr_pkg::P_IDLE;
      atr_pkg::P_CSQ_D1:    pos_nxt = is_digit ? atr_pkg::P_CSQ_D2 : atr_pkg::P_IDLE;
      atr_pkg::P_CSQ_D2:    pos_nxt = expect_ch(byte_i, atr_pkg::CH_COMMA, atr_pkg::P_CSQ_COM);
      atr_pkg::P_CR:        pos_nxt = expect_ch(byte_i, atr_pkg::CH_E, atr_pkg::P_CRE);
      atr_pkg::P_CRE:       pos_nxt = expect_ch(byte_i, atr_pkg::CH_G, atr_pkg::P_CREG);
      atr_pkg::P_CREG:      pos_nxt = expect_ch(byte_i, atr_pkg::CH_COLON, atr_pkg::P_CREG_COL);
      atr_pkg::P_CREG_COL:  pos_nxt = expect_ch(byte_i, atr_pkg::CH_SP, atr_pkg::P_CREG_SP);
      atr_pkg::P_CREG_SP:   pos_nxt = expect_ch(byte_i, atr_pkg::CH_0, atr_pkg::P_CREG_0);
      atr_pkg::P_CREG_0:    pos_nxt = expect_ch(byte_i, atr_pkg::CH_COMMA, atr_pkg::P_CREG_COM);
      atr_pkg::P_S:         pos_nxt = expect_ch(byte_i, atr_pkg::CH_A, atr_pkg::P_SA);
      atr_pkg::P_SA:        pos_nxt = expect_ch(byte_i, atr_pkg::CH_P, atr_pkg::P_SAP);
      atr_pkg::P_SAP:       pos_nxt = expect_ch(byte_i, atr_pkg::CH_B, atr_pkg::P_SAPB);
      atr_pkg::P_SAPB:      pos_nxt = expect_ch(byte_i, atr_pkg::CH_R, atr_pkg::P_SAPBR);
      atr_pkg::P_SAPBR:     pos_nxt = expect_ch(byte_i, atr_pkg::CH_COLON, atr_pkg::P_SAPBR_COL);
      atr_pkg::P_SAPBR_COL: pos_nxt = expect_ch(byte_i, atr_pkg::CH_SP, atr_pkg::P_SAPBR_SP);
      atr_pkg::P_SAPBR_SP:  pos_nxt = expect_ch(byte_i, atr_pkg::CH_1, atr_pkg::P_SAPBR_1);
      atr_pkg::P_SAPBR_1:   pos_nxt = expect_ch(byte_i, atr_pkg::CH_COMMA, atr_pkg::P_SAPBR_COM);
      atr_pkg::P_D:         pos_nxt = expect_ch(byte_i, atr_pkg::CH_O, atr_pkg::P_DO);
      atr_pkg::P_DO:        pos_nxt = expect_ch(byte_i, atr_pkg::CH_W, atr_pkg::P_DOW);
      atr_pkg::P_DOW:       pos_nxt = expect_ch(byte_i, atr_pkg::CH_N, atr_pkg::P_DOWN);
      atr_pkg::P_DOWN:      pos_nxt = expect_ch(byte_i, atr_pkg::CH_L, atr_pkg::P_DOWNL);
      atr_pkg::P_DOWNL:     pos_nxt = expect_ch(byte_i, atr_pkg::CH_O, atr_pkg::P_DOWNLO);
      atr_pkg::P_DOWNLO:    pos_nxt = expect_ch(byte_i, atr_pkg::CH_A, atr_pkg::P_DOWNLOA);
      atr_pkg::P_H:         pos_nxt = expect_ch(byte_i, atr_pkg::CH_T, atr_pkg::P_HT);
      atr_pkg::P_HT:        pos_nxt = expect_ch(byte_i, atr_pkg::CH_T, atr_pkg::P_HTT);
      atr_pkg::P_HTT:       pos_nxt = expect_ch(byte_i, atr_pkg::CH_P, atr_pkg::P_HTTP);
      atr_pkg::P_HTTP:      pos_nxt = expect_ch(byte_i, atr_pkg::CH_A, atr_pkg::P_HTTPA);
      atr_pkg::P_HTTPA:     pos_nxt = expect_ch(byte_i, atr_pkg::CH_C, atr_pkg::P_HTTPAC);
      atr_pkg::P_HTTPAC:    pos_nxt = expect_ch(byte_i, atr_pkg::CH_T, atr_pkg::P_HTTPACT);
      atr_pkg::P_HTTPACT:   pos_nxt = expect_ch(byte_i, atr_pkg::CH_I, atr_pkg::P_HTTPACTI);
      atr_pkg::P_HTTPACTI:  pos_nxt = expect_ch(byte_i, atr_pkg::CH_O, atr_pkg::P_HTTPACTIO);
      atr_pkg::P_HTTPACTIO: pos_nxt = expect_ch(byte_i, atr_pkg::CH_N, atr_pkg::P_HTTPACTION);
      atr_pkg::P_HTTPACTION:
        pos_nxt = expect_ch(byte_i, atr_pkg::CH_COLON, atr_pkg::P_HA_COL);
      atr_pkg::P_HA_COL:    pos_nxt = expect_ch(byte_i, atr_pkg::CH_SP, atr_pkg::P_HA_SP);
      atr_pkg::P_HA_SP:     pos_nxt = expect_ch(byte_i, atr_pkg::CH_1, atr_pkg::P_HA_1);
      atr_pkg::P_HA_1:      pos_nxt = expect_ch(byte_i, atr_pkg::CH_COMMA, atr_pkg::P_HA_COM);
      atr_pkg::P_HA_COM:    pos_nxt = is_digit ? atr_pkg::P_HA_D1 : atr_pkg::P_IDLE;
      atr_pkg::P_HA_D1:     pos_nxt = is_digit ? atr_pkg::P_HA_DN : atr_pkg::P_IDLE;
      atr_pkg::P_HA_DN:     pos_nxt = is_digit ? atr_pkg::P_HA_DN : atr_pkg::P_IDLE;
      atr_pkg::P_E:         pos_nxt = expect_ch(byte_i, atr_pkg::CH_R, atr_pkg::P_ER);
      atr_pkg::P_ER: begin
        priority if (byte_i == atr_pkg::CH_R) pos_nxt = atr_pkg::P_ER;
        else if (byte_i == atr_pkg::CH_O)     pos_nxt = atr_pkg::P_ERRO;
        else                                  pos_nxt = atr_pkg::P_IDLE;
      end
      default:              pos_nxt = atr_pkg::P_IDLE;
    endcase
  end

  always_comb begin
    set_nxt = '0;
    unique case (pos_i)
      atr_pkg::P_O_WAIT:    set_nxt[atr_pkg::FLAG_OK]     = (byte_i == atr_pkg::CH_K);
      atr_pkg::P_GT_WAIT:   set_nxt[atr_pkg::FLAG_PROMPT] = (byte_i == atr_pkg::CH_SP);
      atr_pkg::P_CMG:       set_nxt[atr_pkg::FLAG_SENT]   = (byte_i == atr_pkg::CH_S);
      atr_pkg::P_CSQ_COM:   set_nxt[atr_pkg::FLAG_SIGNAL] = is_digit;
      atr_pkg::P_CREG_COM:  set_nxt[atr_pkg::FLAG_REG]    = (byte_i == atr_pkg::CH_1);
      atr_pkg::P_SAPBR_COM: set_nxt[atr_pkg::FLAG_BEARER] = (byte_i == atr_pkg::CH_1);
      atr_pkg::P_DOWNLOA:   set_nxt[atr_pkg::FLAG_DLOAD]  = (byte_i == atr_pkg::CH_D);
      atr_pkg::P_HA_DN:     set_nxt[atr_pkg::FLAG_HTTP]   = (byte_i == atr_pkg::CH_COMMA);
      atr_pkg::P_ERRO:      set_nxt[atr_pkg::FLAG_ERROR]  = (byte_i == atr_pkg::CH_R);
      default:              set_nxt = '0;
    endcase
  end

  assign step_o.pos = pos_nxt;
  assign step_o.set = set_nxt;

endmodule

/* sim/tb_at_response_recognizer_top.sv */
// Self-checking testbench for at_response_recognizer_top: streams modem bytes and
// clear beats, predicts flags and matcher status per beat and checks every result.
// Depends on atr_pkg and the recognizer RTL only.
`timescale 1ns / 1ps

module tb_at_response_recognizer_top;
  import atr_pkg::*;

  localparam int unsigned RandomBeats = 950;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAt      = 700;

  typedef struct packed {
    logic             op;
    logic [7:0]       rx_byte;
    logic [FlagW-1:0] clear_mask;
  } modem_beat_t;

  typedef struct packed {
    logic [4:0]       pad;
    logic             mid_match;
    logic [FlagW-1:0] response_flags;
  } status_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  modem_beat_t      pending_beats[$];
  status_beat_t     expected_status[$];
  logic [7:0]       burst[$];
  modem_beat_t      offered_beat;
  pos_e             model_pos = P_IDLE;
  logic [FlagW-1:0] model_flags = '0;
  int unsigned      beats_sent = 0;
  int unsigned      cycle_count = 0;
  int unsigned      hold_left = 0;
  bit               hold_done = 1'b0;
  bit               failed = 1'b0;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;

  at_response_recognizer_top dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic pos_e step_if(logic [7:0] c, logic [7:0] want, pos_e nxt);
    return (c == want) ? nxt : P_IDLE;
  endfunction

  function automatic pos_e next_position(pos_e p, logic [7:0] c);
    case (p)
      P_IDLE: begin
        if (c == CH_O) return P_O_WAIT;
        if (c == CH_PLUS) return P_PLUS;
        if (c == CH_GT) return P_GT_WAIT;
        if (c == CH_D) return P_D;
        if (c == CH_E) return P_E;
        return P_IDLE;
      end
      P_O_WAIT: begin
        if (c == CH_K) begin
          model_flags[FLAG_OK] = 1'b1;
          return P_IDLE;
        end
        return P_O_WAIT;
      end
      P_GT_WAIT: begin
        if (c == CH_SP) begin
          model_flags[FLAG_PROMPT] = 1'b1;
          return P_PROMPT;
        end
        return P_GT_WAIT;
      end
      P_PROMPT: return step_if(c, CH_PLUS, P_PLUS);
      P_PLUS: begin
        if (c == CH_C) return P_C;
        if (c == CH_S) return P_S;
        if (c == CH_H) return P_H;
        return P_IDLE;
      end
      P_C: begin
        if (c == CH_M) return P_CM;
        if (c == CH_S) return P_CS;
        if (c == CH_R) return P_CR;
        return P_IDLE;
      end
      P_CM: return step_if(c, CH_G, P_CMG);
      P_CMG: begin
        if (c == CH_S) model_flags[FLAG_SENT] = 1'b1;
        return P_IDLE;
      end
      P_CS:      return step_if(c, CH_Q, P_CSQ);
      P_CSQ:     return step_if(c, CH_COLON, P_CSQ_COL);
      P_CSQ_COL: return step_if(c, CH_SP, P_CSQ_SP);
      P_CSQ_SP:  return (c >= CH_1 && c <= CH_3) ? P_CSQ_D1 : P_IDLE;
      P_CSQ_D1:  return is_digit(c) ? P_CSQ_D2 : P_IDLE;
      P_CSQ_D2:  return step_if(c, CH_COMMA, P_CSQ_COM);
      P_CSQ_COM: begin
        if (is_digit(c)) model_flags[FLAG_SIGNAL] = 1'b1;
        return P_IDLE;
      end
      P_CR:       return step_if(c, CH_E, P_CRE);
      P_CRE:      return step_if(c, CH_G, P_CREG);
      P_CREG:     return step_if(c, CH_COLON, P_CREG_COL);
      P_CREG_COL: return step_if(c, CH_SP, P_CREG_SP);
      P_CREG_SP:  return step_if(c, CH_0, P_CREG_0);
      P_CREG_0:   return step_if(c, CH_COMMA, P_CREG_COM);
      P_CREG_COM: begin
        if (c == CH_1) model_flags[FLAG_REG] = 1'b1;
        return P_IDLE;
      end
      P_S:           return step_if(c, CH_A, P_SA);
      P_SA:          return step_if(c, CH_P, P_SAP);
      P_SAP:         return step_if(c, CH_B, P_SAPB);
      P_SAPB:        return step_if(c, CH_R, P_SAPBR);
      P_SAPBR:       return step_if(c, CH_COLON, P_SAPBR_COL);
      P_SAPBR_COL:   return step_if(c, CH_SP, P_SAPBR_SP);
      P_SAPBR_SP:    return step_if(c, CH_1, P_SAPBR_1);
      P_SAPBR_1:     return step_if(c, CH_COMMA, P_SAPBR_COM);
      P_SAPBR_COM: begin
        if (c == CH_1) model_flags[FLAG_BEARER] = 1'b1;
        return P_IDLE;
      end
      P_D:      return step_if(c, CH_O, P_DO);
      P_DO:     return step_if(c, CH_W, P_DOW);
      P_DOW:    return step_if(c, CH_N, P_DOWN);
      P_DOWN:   return step_if(c, CH_L, P_DOWNL);
      P_DOWNL:  return step_if(c, CH_O, P_DOWNLO);
      P_DOWNLO: return step_if(c, CH_A, P_DOWNLOA);
      P_DOWNLOA: begin
        if (c == CH_D) model_flags[FLAG_DLOAD] = 1'b1;
        return P_IDLE;
      end
      P_H:           return step_if(c, CH_T, P_HT);
      P_HT:          return step_if(c, CH_T, P_HTT);
      P_HTT:         return step_if(c, CH_P, P_HTTP);
      P_HTTP:        return step_if(c, CH_A, P_HTTPA);
      P_HTTPA:       return step_if(c, CH_C, P_HTTPAC);
      P_HTTPAC:      return step_if(c, CH_T, P_HTTPACT);
      P_HTTPACT:     return step_if(c, CH_I, P_HTTPACTI);
      P_HTTPACTI:    return step_if(c, CH_O, P_HTTPACTIO);
      P_HTTPACTIO:   return step_if(c, CH_N, P_HTTPACTION);
      P_HTTPACTION:  return step_if(c, CH_COLON, P_HA_COL);
      P_HA_COL:      return step_if(c, CH_SP, P_HA_SP);
      P_HA_SP:       return step_if(c, CH_1, P_HA_1);
      P_HA_1:        return step_if(c, CH_COMMA, P_HA_COM);
      P_HA_COM:      return is_digit(c) ? P_HA_D1 : P_IDLE;
      P_HA_D1:       return is_digit(c) ? P_HA_DN : P_IDLE;
      P_HA_DN: begin
        if (is_digit(c)) return P_HA_DN;
        if (c == CH_COMMA) model_flags[FLAG_HTTP] = 1'b1;
        return P_IDLE;
      end
      P_E: return step_if(c, CH_R, P_ER);
      P_ER: begin
        if (c == CH_R) return P_ER;
        if (c == CH_O) return P_ERRO;
        return P_IDLE;
      end
      P_ERRO: begin
        if (c == CH_R) model_flags[FLAG_ERROR] = 1'b1;
        return P_IDLE;
      end
      default: return P_IDLE;
    endcase
  endfunction

  function automatic void predict_status(modem_beat_t b);
    status_beat_t s;
    if (b.op == OP_BYTE) begin
      model_pos = next_position(model_pos, b.rx_byte);
    end else begin
      model_flags = model_flags & ~b.clear_mask;
    end
    s.pad            = '0;
    s.mid_match      = (model_pos != P_IDLE);
    s.response_flags = model_flags;
    expected_status.push_back(s);
  endfunction

  task automatic add_byte(logic [7:0] c);
    modem_beat_t b;
    b.op         = OP_BYTE;
    b.rx_byte    = c;
    b.clear_mask = FlagW'($urandom_range(1023));
    pending_beats.push_back(b);
  endtask

  task automatic add_clear(logic [FlagW-1:0] mask);
    modem_beat_t b;
    b.op         = OP_CLEAR;
    b.rx_byte    = 8'($urandom_range(255));
    b.clear_mask = mask;
    pending_beats.push_back(b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endtask

  task automatic add_digit();
    burst.push_back(CH_0 + 8'($urandom_range(9)));
  endtask

  task automatic add_response();
    int unsigned kind;
    int unsigned idx;
    int unsigned n;
    burst.delete();
    kind = $urandom_range(12);
    case (kind)
      0: begin
        burst.push_back(CH_O);
        n = $urandom_range(2);
        repeat (n) burst.push_back(8'($urandom_range(255)));
        burst.push_back(CH_K);
      end
      1: begin
        add_text(">");
        n = $urandom_range(2);
        repeat (n) burst.push_back(8'($urandom_range(255)));
        add_text(" ");
        if ($urandom_range(1)) add_text("+CMGS");
      end
      2: add_text("+CMGS");
      3: begin
        add_text("+CSQ: ");
        if ($urandom_range(3) == 0) add_digit();
        else burst.push_back(CH_1 + 8'($urandom_range(2)));
        add_digit();
        add_text(",");
        add_digit();
      end
      4: add_text("+CREG: 0,1");
      5: add_text("+SAPBR: 1,1");
      6: add_text("DOWNLOAD");
      7: begin
        add_text("+HTTPACTION: 1,");
        n = $urandom_range(5, 1);
        repeat (n) add_digit();
        add_text(",");
      end
      8: begin
        add_text("ER");
        n = $urandom_range(3);
        repeat (n) add_text("R");
        add_text("OR");
      end
      9: begin
        if ($urandom_range(3) == 0) add_clear({FlagW{1'b1}});
        else add_clear(FlagW'($urandom_range(1023)));
      end
      default: begin
        n = $urandom_range(3, 1);
        repeat (n) burst.push_back(8'($urandom_range(255)));
      end
    endcase
    if (burst.size() > 1 && $urandom_range(99) < 15) begin
      idx = $urandom_range(burst.size() - 1);
      if ($urandom_range(1)) begin
        burst[idx] = 8'($urandom_range(255));
      end else begin
        while (burst.size() > idx + 1) void'(burst.pop_back());
      end
    end
    foreach (burst[i]) add_byte(burst[i]);
  endtask

  always_comb begin
    if (beats_sent < 320) begin
      send_idle_pct = 20;
      recv_idle_pct = 51;
    end else if (beats_sent < 640) begin
      send_idle_pct = 51;
      recv_idle_pct = 20;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_status(offered_beat);
        beats_sent <= beats_sent + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_beat = pending_beats.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {6'b0, offered_beat.clear_mask, offered_beat.rx_byte};
          s_axis_tuser_i  <= offered_beat.op;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!hold_done && beats_sent >= HoldAt) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    status_beat_t got;
    status_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (expected_status.size() == 0) begin
        $error("unexpected result beat %h", got);
        failed = 1'b1;
      end else begin
        want = expected_status.pop_front();
        if (got.response_flags !== want.response_flags) begin
          $error("response_flags expected %h actual %h", want.response_flags,
                 got.response_flags);
          failed = 1'b1;
        end
        if (got.mid_match !== want.mid_match) begin
          $error("mid_match expected %b actual %b", want.mid_match, got.mid_match);
          failed = 1'b1;
        end
        if (got.pad !== want.pad) begin
          $error("pad expected %h actual %h", want.pad, got.pad);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned directed;
    // Field extremes, the wait-for-K and wait-for-space cases, prompt continuing
    // into a keyword, repeated R in ERROR, and clears with empty and full masks.
    add_clear('0);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("OzK");
    add_text(">q ");
    add_text("+CMGS");
    add_text("ERRROR");
    foreach (burst[i]) add_byte(burst[i]);
    add_clear({FlagW{1'b1}});
    add_clear(10'h2AA);
    directed = pending_beats.size();
    while (pending_beats.size() < directed + RandomBeats) add_response();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_beats.size() > 0 || s_axis_tvalid_i || expected_status.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (!failed && expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
